@@ rtl/lcm_of_three_by_prime_factors_macros.svh @@
// Assertion helpers used by the RTL top
`ifndef LCM_OF_THREE_BY_PRIME_FACTORS_MACROS_SVH
`define LCM_OF_THREE_BY_PRIME_FACTORS_MACROS_SVH

// same-cycle implication
`define LCM3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCM3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lcm3_pkg.sv @@
package lcm3_pkg;
    localparam int MULTIPLE_WIDTH = 48;
    localparam int FIELD_WIDTH    = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DSTART,
        S_DWAIT,
        S_APPLY,
        S_MUL,
        S_NEXT,
        S_PTEST,
        S_PWAIT,
        S_DONE
    } t_state;
endpackage

@@ rtl/lcm3_div.sv @@
module lcm3_div import lcm3_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_num, n_num;
    logic [W-1:0]  r_den, n_den;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W:0]    sh;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign sh = {r_rem, r_num[W-1]};
    assign ge = sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_num = {r_num[W-2:0], 1'b0};
            n_rem = ge ? W'(sh - {1'b0, r_den}) : W'(sh);
            n_quo = {r_quo[W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ rtl/lcm_of_three_by_prime_factors.sv @@
// LCM of three unsigned operands by walking prime factors. Pulse start while busy is
// low; one result word appears on o_multiple/o_bad_operand for exactly one cycle with
// o_valid high, and cannot be held off. A zero operand gives o_bad_operand = 1 and
// o_multiple = 0. Otherwise every trial division runs through one shared bit-serial
// divider and every multiply through a bit-serial shift-add unit; the number of trial
// divisions in the prime search sets the latency.
module lcm_of_three_by_prime_factors import lcm3_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [FIELD_WIDTH-1:0]    i_operand_a,
    input  logic [FIELD_WIDTH-1:0]    i_operand_b,
    input  logic [FIELD_WIDTH-1:0]    i_operand_c,
    output logic                      busy,
    output logic                      o_valid,
    output logic [MULTIPLE_WIDTH-1:0] o_multiple,
    output logic                      o_bad_operand
);
    `include "lcm_of_three_by_prime_factors_macros.svh"

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    t_state r_state, n_state;

    logic [W-1:0]  r_a, n_a, r_b, n_b, r_c, n_c;
    logic [W-1:0]  r_qa, n_qa, r_qb, n_qb, r_qc, n_qc;
    logic [2:0]    r_hit, n_hit;
    logic [1:0]    r_sel, n_sel;
    logic [W-1:0]  r_p, n_p, r_q, n_q, r_f, n_f;
    logic [W+1:0]  r_fsq, n_fsq;
    logic          r_bad, n_bad;
    logic [MULTIPLE_WIDTH-1:0] r_acc, n_acc, r_mcand, n_mcand;
    logic [W-1:0]  r_mplier, n_mplier;
    logic [CW-1:0] r_mcnt, n_mcnt;
    logic          r_valid, n_valid;
    logic [MULTIPLE_WIDTH-1:0] r_out, n_out;
    logic          r_obad, n_obad;

    logic          div_start, div_done;
    logic [W-1:0]  div_num, div_den, div_quo, div_rem;
    logic [W-1:0]  sel_op;

    lcm3_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_comb begin
        case (r_sel)
            2'd0:    sel_op = r_a;
            2'd1:    sel_op = r_b;
            default: sel_op = r_c;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_a = r_a; n_b = r_b; n_c = r_c;
        n_qa = r_qa; n_qb = r_qb; n_qc = r_qc;
        n_hit    = r_hit;
        n_sel    = r_sel;
        n_p = r_p; n_q = r_q; n_f = r_f; n_fsq = r_fsq;
        n_bad    = r_bad;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_mcnt   = r_mcnt;
        n_valid  = 1'b0;
        n_out    = r_out;
        n_obad   = r_obad;
        div_start = 1'b0;
        div_num   = sel_op;
        div_den   = r_p;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_a   = W'(i_operand_a);
                    n_b   = W'(i_operand_b);
                    n_c   = W'(i_operand_c);
                    n_bad = (W'(i_operand_a) == '0) || (W'(i_operand_b) == '0)
                         || (W'(i_operand_c) == '0);
                    n_acc = MULTIPLE_WIDTH'(1);
                    n_p   = W'(2);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_sel = 2'd0;
                if (r_bad || (r_a <= W'(1) && r_b <= W'(1) && r_c <= W'(1)))
                    n_state = S_DONE;
                else
                    n_state = S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    case (r_sel)
                        2'd0:    begin n_qa = div_quo; n_hit[0] = (div_rem == '0); end
                        2'd1:    begin n_qb = div_quo; n_hit[1] = (div_rem == '0); end
                        default: begin n_qc = div_quo; n_hit[2] = (div_rem == '0); end
                    endcase
                    if (r_sel == 2'd2) begin
                        n_state = S_APPLY;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_DSTART;
                    end
                end
            end
            S_APPLY: begin
                if (r_hit != 3'b000) begin
                    if (r_hit[0]) n_a = r_qa;
                    if (r_hit[1]) n_b = r_qb;
                    if (r_hit[2]) n_c = r_qc;
                    n_mcand  = r_acc;
                    n_mplier = r_p;
                    n_acc    = '0;
                    n_mcnt   = CW'(W);
                    n_state  = S_MUL;
                end else begin
                    n_state = S_NEXT;
                end
                n_hit = 3'b000;
            end
            S_MUL: begin
                // shift-add one multiplier bit per cycle
                if (r_mplier[0])
                    n_acc = r_acc + r_mcand;
                n_mcand  = {r_mcand[MULTIPLE_WIDTH-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[W-1:1]};
                n_mcnt   = r_mcnt - 1'b1;
                if (r_mcnt == CW'(1))
                    n_state = S_CHECK;
            end
            S_NEXT: begin
                if (r_p == W'(2)) begin
                    n_p     = W'(3);
                    n_state = S_CHECK;
                end else begin
                    n_q     = r_p + W'(2);
                    n_f     = W'(3);
                    n_fsq   = (W+2)'(9);
                    n_state = S_PTEST;
                end
            end
            S_PTEST: begin
                div_num = r_q;
                div_den = r_f;
                if (r_fsq > {2'b00, r_q}) begin
                    n_p     = r_q;
                    n_state = S_CHECK;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_PWAIT;
                end
            end
            S_PWAIT: begin
                div_num = r_q;
                div_den = r_f;
                if (div_done) begin
                    if (div_rem == '0) begin
                        // composite: next odd candidate
                        n_q   = r_q + W'(2);
                        n_f   = W'(3);
                        n_fsq = (W+2)'(9);
                    end else begin
                        // (f+2)^2 = f^2 + 4f + 4
                        n_f   = r_f + W'(2);
                        n_fsq = r_fsq + {r_f, 2'b00} + (W+2)'(4);
                    end
                    n_state = S_PTEST;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_out   = r_bad ? '0 : r_acc;
                n_obad  = r_bad;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_hit   <= 3'b000;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_hit   <= n_hit;
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c;
        r_qa <= n_qa; r_qb <= n_qb; r_qc <= n_qc;
        r_sel    <= n_sel;
        r_p <= n_p; r_q <= n_q; r_f <= n_f; r_fsq <= n_fsq;
        r_bad    <= n_bad;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_mcnt   <= n_mcnt;
        r_out    <= n_out;
        r_obad   <= n_obad;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_multiple    = r_out;
    assign o_bad_operand = r_obad;

    `LCM3_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result strobe while busy")
    `LCM3_ASSERT_NOW(a_bad_zero, o_valid && o_bad_operand, o_multiple == '0, "bad word nonzero")
    `LCM3_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start")
    `LCM3_ASSERT_NOW(a_div_owned, div_done, r_state == S_DWAIT || r_state == S_PWAIT,
        "divider finished outside a wait state")
endmodule
